[src/lpd_pkg.sv]
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants for the length-prefixed deframer with Adler-32.
// ----------------------------------------------------------------------------
package lpd_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned HALF_W    = 16;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [HALF_W-1:0] ADLER_MOD  = 16'd65521;
	localparam logic [WORD_W-1:0] MIN_LEN    = 32'd8;
	localparam logic [WORD_W-1:0] MAX_LEN_RST = 32'd100000000;

	// request queue between front and back
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_WORD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN   = 2'd1;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISMATCH  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TOO_SHORT = 2'd2;
	localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 2'd3;

	typedef struct packed {
		logic [WORD_W-1:0] sync_word;
		logic [WORD_W-1:0] max_frame_len;
	} cfg_t;

	// one queued result request
	typedef struct packed {
		logic [BYTE_W-1:0]   data;
		logic                has_byte;
		logic                last;
		logic [STATUS_W-1:0] status;
		logic                adler_en;
	} req_t;

endpackage

[src/lpd_front.sv]
// ----------------------------------------------------------------------------
// lpd_front
// Stream parser: header, body and hunt phases; emits result requests.
// ----------------------------------------------------------------------------
module lpd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lpd_pkg::BYTE_W-1:0]    in_byte,
	input  lpd_pkg::cfg_t                 cfg,
	input  logic [lpd_pkg::WORD_W-1:0]    adler_sum,
	input  logic                          q_full,
	output logic                          push,
	output lpd_pkg::req_t                 push_req
);
	import lpd_pkg::*;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_BODY   = 2'd1,
		PH_HUNT   = 2'd2
	} phase_t;

	phase_t                    phase_q;
	logic [1:0]                hdr_cnt_q;
	logic [WORD_W-BYTE_W-1:0]  flen_q;     // lower three length bytes seen so far
	logic [WORD_W-1:0]         remain_q;   // bytes left in body after this one
	logic [WORD_W-1:0]         recv_q;
	logic [23:0]               win_q;
	logic [1:0]                fill_q;

	logic                accept;
	logic [WORD_W-1:0]   cand;
	logic                flag_hit;
	logic [WORD_W-1:0]   hdr_len;
	logic                too_long;
	logic                too_short;
	logic                body_last;
	logic                sum_byte;
	logic                chk_byte;
	logic                mismatch;
	logic                need_push;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	assign cand      = {in_byte, win_q};
	assign flag_hit  = (cand == cfg.sync_word);
	assign hdr_len   = {in_byte, flen_q};
	assign too_long  = (hdr_len > cfg.max_frame_len);
	assign too_short = (hdr_len < MIN_LEN);
	assign body_last = (remain_q == '0);
	assign sum_byte  = (remain_q[WORD_W-1:3] != '0);               // remain >= 8
	assign chk_byte  = !sum_byte && (remain_q[2] == 1'b1);         // remain 4..7
	// adler from back is final here: queue is shallower than the trailer
	assign mismatch  = (adler_sum != recv_q);

	always_comb begin
		need_push = 1'b0;
		push_req  = '0;
		case (phase_q)
			PH_BODY: begin
				need_push         = 1'b1;
				push_req.data     = in_byte;
				push_req.has_byte = 1'b1;
				push_req.last     = body_last;
				push_req.status   = (body_last && mismatch) ? ST_MISMATCH : ST_OK;
				push_req.adler_en = sum_byte;
			end
			PH_HUNT: begin
				need_push = 1'b0;
			end
			default: begin
				if (hdr_cnt_q == 2'd3 && (too_long || too_short)) begin
					need_push       = 1'b1;
					push_req.last   = 1'b1;
					push_req.status = too_long ? ST_TOO_LONG : ST_TOO_SHORT;
				end
			end
		endcase
	end

	assign push = accept && need_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_cnt_q <= '0;
			flen_q    <= '0;
			remain_q  <= '0;
			recv_q    <= '0;
			win_q     <= '0;
			fill_q    <= '0;
		end else if (accept) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (fill_q == 2'd3 && flag_hit) begin
						phase_q   <= PH_HEADER;
						hdr_cnt_q <= '0;
						flen_q    <= '0;
						win_q     <= '0;
						fill_q    <= '0;
					end else begin
						win_q <= {in_byte, win_q[23:BYTE_W]};
						if (fill_q != 2'd3) begin
							fill_q <= fill_q + 2'd1;
						end
					end
				end
				PH_BODY: begin
					if (chk_byte) begin
						recv_q <= {in_byte, recv_q[WORD_W-1:BYTE_W]};
					end
					if (body_last) begin
						if (mismatch && !flag_hit) begin
							phase_q <= PH_HUNT;
						end else begin
							phase_q   <= PH_HEADER;
							hdr_cnt_q <= '0;
							flen_q    <= '0;
						end
						win_q  <= '0;
						fill_q <= '0;
					end else begin
						win_q    <= {in_byte, win_q[23:BYTE_W]};
						remain_q <= remain_q - WORD_W'(1);
					end
				end
				default: begin
					phase_q   <= PH_HEADER;
					flen_q    <= hdr_len[WORD_W-1:BYTE_W];
					hdr_cnt_q <= hdr_cnt_q + 2'd1;
					if (hdr_cnt_q == 2'd3) begin
						win_q  <= '0;
						fill_q <= '0;
						if (too_long || too_short) begin
							phase_q <= PH_HUNT;
						end else begin
							phase_q  <= PH_BODY;
							remain_q <= hdr_len - WORD_W'(1);
							recv_q   <= '0;
						end
					end
				end
			endcase
		end
	end

endmodule

[src/lpd_queue.sv]
// ----------------------------------------------------------------------------
// lpd_queue
// Small request FIFO between parser and checksum/output stage.
// ----------------------------------------------------------------------------
module lpd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lpd_pkg::req_t  push_req,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output lpd_pkg::req_t  head
);
	import lpd_pkg::*;

	req_t               slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = (count_q == Q_CNT_W'(Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + Q_CNT_W'(1);
				2'b01:   count_q <= count_q - Q_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/lpd_back.sv]
// ----------------------------------------------------------------------------
// lpd_back
// Adler-32 accumulation and registered result output.
// ----------------------------------------------------------------------------
module lpd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_not_empty,
	input  lpd_pkg::req_t                 q_head,
	output logic                          q_pop,
	output logic [lpd_pkg::WORD_W-1:0]    adler_sum,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lpd_pkg::BYTE_W-1:0]    out_byte,
	output logic                          has_byte,
	output logic                          frame_last,
	output logic [lpd_pkg::STATUS_W-1:0]  status
);
	import lpd_pkg::*;

	logic [HALF_W-1:0] a_lo_q;
	logic [HALF_W-1:0] a_hi_q;
	logic              valid_q;
	req_t              res_q;

	logic [HALF_W:0]   lo_sum;
	logic [HALF_W-1:0] lo_next;
	logic [HALF_W:0]   hi_sum;
	logic [HALF_W-1:0] hi_next;

	assign q_pop = q_not_empty && (!valid_q || out_ready);

	always_comb begin
		lo_sum  = {1'b0, a_lo_q} + {{(HALF_W + 1 - BYTE_W){1'b0}}, q_head.data};
		lo_next = (lo_sum >= {1'b0, ADLER_MOD}) ? HALF_W'(lo_sum - {1'b0, ADLER_MOD})
			: lo_sum[HALF_W-1:0];
		hi_sum  = {1'b0, a_hi_q} + {1'b0, lo_next};
		hi_next = (hi_sum >= {1'b0, ADLER_MOD}) ? HALF_W'(hi_sum - {1'b0, ADLER_MOD})
			: hi_sum[HALF_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_lo_q  <= HALF_W'(1);
			a_hi_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_q <= 1'b1;
				if (q_head.last) begin
					a_lo_q <= HALF_W'(1);
					a_hi_q <= '0;
				end else if (q_head.adler_en) begin
					a_lo_q <= lo_next;
					a_hi_q <= hi_next;
				end
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= q_head;
		end
	end

	assign adler_sum  = {a_hi_q, a_lo_q};
	assign out_valid  = valid_q;
	assign out_byte   = res_q.data;
	assign has_byte   = res_q.has_byte;
	assign frame_last = res_q.last;
	assign status     = res_q.status;

endmodule

[src/length_prefixed_deframer_adler32.sv]
// ----------------------------------------------------------------------------
// length_prefixed_deframer_adler32
// Deframes length-prefixed frames, passes body bytes through and checks the
// Adler-32 trailer of each frame.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | dir | note
//  --------+-------------------------------------------+-----+-------------------
//  in      | in_valid, in_ready, in_byte               | in  | one stream byte
//  out     | out_valid, out_ready, out_byte, has_byte, | out | body byte or
//          | frame_last, status                        |     | status-only result
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in  | 0 sync word,
//          |                                           |     | 1 max_frame_len
//
//  One byte per cycle sustained with out_ready high. A body byte is written
//  into the queue when accepted and moves to the output register when the
//  back stage pops it, so out_valid follows the accept through both registers.
//  Header and hunt bytes produce no result; a rejected length gives one
//  status-only result. Reset is asynchronous and clears all control state.
//  in_ready drops only while the 4-entry queue is full; cfg_ready is always high.
//
module length_prefixed_deframer_adler32 (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [lpd_pkg::BYTE_W-1:0]          in_byte,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [lpd_pkg::BYTE_W-1:0]          out_byte,
	output logic                                has_byte,
	output logic                                frame_last,
	output logic [lpd_pkg::STATUS_W-1:0]        status,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lpd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lpd_pkg::WORD_W-1:0]          cfg_data
);
	import lpd_pkg::*;

	// configuration registers
	logic [WORD_W-1:0] sync_word_q;
	logic [WORD_W-1:0] max_len_q;
	cfg_t              cfg;

	// front -> queue -> back
	logic              push;
	req_t              push_req;
	logic              q_full;
	logic              q_pop;
	logic              q_not_empty;
	req_t              q_head;
	logic [WORD_W-1:0] adler_sum;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_word_q <= '0;
			max_len_q   <= MAX_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SYNC_WORD: sync_word_q <= cfg_data;
				REG_MAX_LEN:   max_len_q   <= cfg_data;
				default:       ;  // unknown index: write dropped
			endcase
		end
	end

	assign cfg.sync_word     = sync_word_q;
	assign cfg.max_frame_len = max_len_q;

	// Parser: tracks header / body / hunt and decides each byte's verdict.
	// The checksum verdict uses the back stage's running sum, which is
	// complete by the last body byte because the queue is shorter than the
	// 8-byte trailer.
	lpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.cfg       (cfg),
		.adler_sum (adler_sum),
		.q_full    (q_full),
		.push      (push),
		.push_req  (push_req)
	);

	lpd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_req  (push_req),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// Back: Adler-32 update on pop, result register toward the consumer.
	lpd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.adler_sum   (adler_sum),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.has_byte    (has_byte),
		.frame_last  (frame_last),
		.status      (status)
	);

endmodule

[src/lpd_checker.sv]
// ----------------------------------------------------------------------------
// lpd_checker
// Port-level checks on the deframer's result stream.
// ----------------------------------------------------------------------------
module lpd_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [lpd_pkg::BYTE_W-1:0]          out_byte,
	input  logic                                has_byte,
	input  logic                                frame_last,
	input  logic [lpd_pkg::STATUS_W-1:0]        status
);
	import lpd_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(has_byte)
			&& $stable(frame_last) && $stable(status))
		else $error("result changed while stalled");

	// status-only result closes a rejection
	a_status_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> frame_last && out_byte == '0
			&& (status == ST_TOO_SHORT || status == ST_TOO_LONG))
		else $error("malformed status-only result");

	// mid-frame bytes carry ok
	a_mid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_last |-> has_byte && status == ST_OK)
		else $error("non-final result with status");

	// last body byte carries a checksum verdict only
	a_last_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_byte && frame_last |-> status == ST_OK || status == ST_MISMATCH)
		else $error("length status on body byte");

endmodule

bind length_prefixed_deframer_adler32 lpd_checker u_lpd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_byte   (out_byte),
	.has_byte   (has_byte),
	.frame_last (frame_last),
	.status     (status)
);
